>>> design/clock_ticks_to_sample_frames_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the clock ticks to sample frames core.
// Each macro checks on the rising edge of clk_i and is off during reset.
// ----------------------------------------------------------------------------
`ifndef CLOCK_TICKS_TO_SAMPLE_FRAMES_CORE_ASSERT_SVH
`define CLOCK_TICKS_TO_SAMPLE_FRAMES_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTTSF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("CTTSF assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CTTSF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("CTTSF assertion failed");

`endif

>>> design/cttsf_pkg.sv
// ----------------------------------------------------------------------------
// cttsf_pkg
// Types, constants and step functions shared by the conversion pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

package cttsf_pkg;

  // Number of restoring division steps for a 64-bit dividend.
  localparam int unsigned DivSteps = 64;
  // Entries in the queue between the front and back parts.
  localparam int unsigned FifoDepth = 2;

  // One stage of the restoring divider.
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] num;
    logic [63:0] freq;
  } div_t;

  // Transaction handed from the front part to the back part.
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] freq;
    logic [31:0] rate;
    logic [63:0] whole;
    logic        bad;
  } mid_t;

  // One stage of the multiply-modulo pipeline.
  typedef struct packed {
    logic [63:0] acc;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] freq;
    logic [63:0] whole;
    logic        bad;
  } mm_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic full;
    logic not_empty;
  } fifo_stat_t;

  // Shift in one dividend bit and subtract the divisor if it fits.
  function automatic div_t div_step(div_t s);
    logic [64:0] t;
    logic [64:0] diff;
    div_t        r;
    t    = {s.rem, s.num[63]};
    diff = t - {1'b0, s.freq};
    r    = s;
    if (!diff[64]) begin
      r.rem = diff[63:0];
      r.num = {s.num[62:0], 1'b1};
    end else begin
      r.rem = t[63:0];
      r.num = {s.num[62:0], 1'b0};
    end
    return r;
  endfunction

  // Double the running remainder modulo the frequency.
  function automatic mm_t mm_double(mm_t s);
    logic [63:0] d;
    logic        wrap;
    mm_t         r;
    d     = s.freq - s.acc;
    wrap  = (s.acc >= d);
    r     = s;
    r.acc = wrap ? (s.acc - d) : (s.acc + s.acc);
    r.q   = {s.q[62:0], wrap};
    return r;
  endfunction

  // Add the position remainder modulo the frequency when the rate bit is set.
  function automatic mm_t mm_add(mm_t s, logic rbit);
    logic [63:0] d;
    mm_t         r;
    d = s.freq - s.rem;
    r = s;
    if (rbit) begin
      if (s.acc >= d) begin
        r.acc = s.acc - d;
        r.q   = s.q + 64'd1;
      end else begin
        r.acc = s.acc + s.rem;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/cttsf_front.sv
// ----------------------------------------------------------------------------
// cttsf_front
// Splits the position into whole seconds and a remainder with a pipelined
// divider, multiplies whole seconds by the rate and flags invalid inputs.
// ----------------------------------------------------------------------------
`default_nettype none

module cttsf_front import cttsf_pkg::*; #(
  parameter int unsigned RATE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] tick_position_i,
  input  wire logic [63:0] tick_frequency_i,
  input  wire logic [31:0] frames_per_second_i,
  output logic             mid_valid_o,
  input  wire logic        mid_ready_i,
  output mid_t             mid_o
);

  localparam logic [31:0] RateMask = 32'((64'd1 << RATE_BITS) - 64'd1);
  // Capture, division steps, multiply and combine.
  localparam int unsigned NStages = DivSteps + 3;

  logic [NStages-1:0] vld_q;
  logic               adv;
  div_t               div_q [DivSteps+1];
  logic [31:0]        rate_q [DivSteps+1];
  logic [63:0]        mul_hi_q, mul_lo_q, mul_rem_q, mul_freq_q;
  logic [31:0]        mul_rate_q;
  logic               mul_zero_q;
  logic [64:0]        whole_sum;
  mid_t               mid_q;

  // The whole pipeline moves when its last stage is free or drains.
  assign adv        = !vld_q[NStages-1] || mid_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStages-2:0], in_valid_i};
    end
  end

  // Input capture.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0]  <= '{rem: '0, num: tick_position_i, freq: tick_frequency_i};
      rate_q[0] <= frames_per_second_i & RateMask;
    end
  end

  // One quotient bit per stage.
  for (genvar k = 1; k <= DivSteps; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[k]  <= div_step(div_q[k-1]);
        rate_q[k] <= rate_q[k-1];
      end
    end
  end

  // Whole seconds times rate as two 32 by 32 partial products.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_hi_q   <= {32'd0, div_q[DivSteps].num[63:32]} * {32'd0, rate_q[DivSteps]};
      mul_lo_q   <= {32'd0, div_q[DivSteps].num[31:0]} * {32'd0, rate_q[DivSteps]};
      mul_rem_q  <= div_q[DivSteps].rem;
      mul_freq_q <= div_q[DivSteps].freq;
      mul_rate_q <= rate_q[DivSteps];
      mul_zero_q <= (div_q[DivSteps].freq == 64'd0) || (rate_q[DivSteps] == 32'd0);
    end
  end

  // Combine the partial products and detect overflow.
  assign whole_sum = {1'b0, mul_hi_q[31:0], 32'd0} + {1'b0, mul_lo_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mid_q.rem   <= mul_rem_q;
      mid_q.freq  <= mul_freq_q;
      mid_q.rate  <= mul_rate_q;
      mid_q.whole <= whole_sum[63:0];
      mid_q.bad   <= mul_zero_q || (mul_hi_q[63:32] != 32'd0) || whole_sum[64];
    end
  end

  assign mid_valid_o = vld_q[NStages-1];
  assign mid_o       = mid_q;

endmodule

`default_nettype wire

>>> design/cttsf_fifo.sv
// ----------------------------------------------------------------------------
// cttsf_fifo
// Small queue that decouples the front and back pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

module cttsf_fifo import cttsf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire mid_t data_i,
  input  wire logic pop_i,
  output mid_t      data_o,
  output fifo_stat_t stat_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  mid_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full      = (cnt_q == CntW'(FifoDepth));
  assign stat_o.not_empty = (cnt_q != '0);
  assign do_push          = push_i && !stat_o.full;
  assign do_pop           = pop_i && stat_o.not_empty;

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(FifoDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o = mem_q[rd_q];

endmodule

`default_nettype wire

>>> design/cttsf_back.sv
// ----------------------------------------------------------------------------
// cttsf_back
// Scales the tick remainder by the rate with a pipelined binary
// multiply-modulo and adds the whole-seconds frames.
// ----------------------------------------------------------------------------
`default_nettype none

module cttsf_back import cttsf_pkg::*; #(
  parameter int unsigned RATE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        mid_valid_i,
  output logic             mid_pop_o,
  input  wire mid_t        mid_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      frame_count_o,
  output logic             conversion_ok_o
);

  // Capture, two half steps per rate bit, output register.
  localparam int unsigned MmStages = 2 * RATE_BITS + 1;
  localparam int unsigned NStages  = MmStages + 1;

  logic [NStages-1:0] vld_q;
  logic               adv;
  mm_t                mm_q [MmStages];
  logic [31:0]        rate_q [MmStages];
  logic [64:0]        total;
  logic [63:0]        count_q;
  logic               ok_q;

  assign adv       = !vld_q[NStages-1] || out_ready_i;
  assign mid_pop_o = adv && mid_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStages-2:0], mid_valid_i};
    end
  end

  // Take the queue head and clear the running remainder and quotient.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mm_q[0]   <= '{acc: '0, q: '0, rem: mid_i.rem, freq: mid_i.freq,
                     whole: mid_i.whole, bad: mid_i.bad};
      rate_q[0] <= mid_i.rate;
    end
  end

  // Rate bits from the most significant down, one doubling and one add each.
  for (genvar j = 0; j < RATE_BITS; j++) begin : g_mm
    always_ff @(posedge clk_i) begin
      if (adv) begin
        mm_q[2*j+1]   <= mm_double(mm_q[2*j]);
        rate_q[2*j+1] <= rate_q[2*j];
        mm_q[2*j+2]   <= mm_add(mm_q[2*j+1], rate_q[2*j+1][RATE_BITS-1-j]);
        rate_q[2*j+2] <= rate_q[2*j+1];
      end
    end
  end

  // Final sum with overflow check into the output register.
  assign total = {1'b0, mm_q[MmStages-1].whole} + {1'b0, mm_q[MmStages-1].q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok_q    <= !mm_q[MmStages-1].bad && !total[64];
      count_q <= (!mm_q[MmStages-1].bad && !total[64]) ? total[63:0] : 64'd0;
    end
  end

  assign out_valid_o     = vld_q[NStages-1];
  assign frame_count_o   = count_q;
  assign conversion_ok_o = ok_q;

endmodule

`default_nettype wire

>>> design/clock_ticks_to_sample_frames_core.sv
// ----------------------------------------------------------------------------
// clock_ticks_to_sample_frames_core
// Converts a clock position in ticks to a sample frame count, exactly:
// floor(position * rate / frequency), with failure on zero or overflow.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_ready_o  tick_position_i,
//                                                tick_frequency_i,
//                                                frames_per_second_i
//   out      output     out_valid_o/out_ready_i  frame_count_o, conversion_ok_o
//
// One transaction is accepted per cycle when nothing stalls.
// Data passes the front part, the queue and the back part: 64 divider
// stages in the front part and two stages per rate bit in the back part.
// Reset clears only valid bits, queue pointers and count; no clear pass needed.
// A stall on out backs up the back part, then the two-entry queue, then in.
// ----------------------------------------------------------------------------
`default_nettype none

`include "clock_ticks_to_sample_frames_core_assert.svh"

module clock_ticks_to_sample_frames_core import cttsf_pkg::*; #(
  parameter int unsigned RATE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] tick_position_i,
  input  wire logic [63:0] tick_frequency_i,
  input  wire logic [31:0] frames_per_second_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      frame_count_o,
  output logic             conversion_ok_o
);

  logic       mid_valid, mid_pop;
  mid_t       mid_in, mid_out;
  fifo_stat_t fifo_stat;

  // Front part: divide, multiply, classify.
  cttsf_front #(.RATE_BITS(RATE_BITS)) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .tick_position_i,
    .tick_frequency_i,
    .frames_per_second_i,
    .mid_valid_o (mid_valid),
    .mid_ready_i (!fifo_stat.full),
    .mid_o       (mid_in)
  );

  // Queue between the two parts.
  cttsf_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i (mid_valid),
    .data_i (mid_in),
    .pop_i  (mid_pop),
    .data_o (mid_out),
    .stat_o (fifo_stat)
  );

  // Back part: multiply-modulo and final sum.
  cttsf_back #(.RATE_BITS(RATE_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .mid_valid_i (fifo_stat.not_empty),
    .mid_pop_o   (mid_pop),
    .mid_i       (mid_out),
    .out_valid_o,
    .out_ready_i,
    .frame_count_o,
    .conversion_ok_o
  );

  // A failed conversion always reports zero frames.
  `CTTSF_ASSERT_IMP(a_fail_zero, out_valid_o && !conversion_ok_o, frame_count_o == 64'd0)
  // The front part only stalls behind a full queue.
  `CTTSF_ASSERT_IMP(a_stall_full, !in_ready_o, mid_valid && fifo_stat.full)
  // A full queue that is not drained stays full.
  `CTTSF_ASSERT_NXT(a_full_holds, fifo_stat.full && !mid_pop, fifo_stat.full)

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Clock ticks to sample frames core testbench
// Drives conversion transactions through the core under random and directed
// traffic, predicts each frame count and compares every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [63:0] tick_position_i;
  logic [63:0] tick_frequency_i;
  logic [31:0] frames_per_second_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] frame_count_o;
  logic        conversion_ok_o;

  // One predicted result.
  typedef struct packed {
    logic [63:0] frames;
    logic        ok;
  } frames_t;

  frames_t     frames_queue[$];
  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned recv_hold_cycles;

  clock_ticks_to_sample_frames_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .tick_position_i    (tick_position_i),
    .tick_frequency_i   (tick_frequency_i),
    .frames_per_second_i(frames_per_second_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .frame_count_o      (frame_count_o),
    .conversion_ok_o    (conversion_ok_o)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Exact floor(pos * rate / freq), with failure on zero or overflow.
  function automatic frames_t convert_ticks(logic [63:0] pos, logic [63:0] freq,
                                            logic [31:0] rate);
    logic [127:0] prod;
    logic [127:0] quo;
    frames_t      r;
    r = '0;
    if (freq != 0 && rate != 0) begin
      prod = {64'd0, pos} * {96'd0, rate};
      quo  = prod / {64'd0, freq};
      // Whole and sum overflow both mean the true quotient exceeds 64 bits.
      if (quo[127:64] == 0) begin
        r.frames = quo[63:0];
        r.ok     = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
    $display("mismatch %s: got %h expected %h", what, got, exp);
    mismatches++;
  endtask

  // Send one conversion transaction and record its prediction.
  // Valid stays high after acceptance until the next transaction or an idle
  // cycle replaces it, so each step sees at most one drive of each input.
  task automatic send_conversion(logic [63:0] pos, logic [63:0] freq,
                                 logic [31:0] rate);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    tick_position_i     <= pos;
    tick_frequency_i    <= freq;
    frames_per_second_i <= rate;
    frames_queue.insert(frames_queue.size(), convert_ticks(pos, freq, rate));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Receiver ready pattern, with an optional long hold-off.
  always @(posedge clk_i) begin
    if (recv_hold_cycles != 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      out_ready_i      <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    frames_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frames_queue.size() == 0) begin
        report_mismatch("unexpected result", frame_count_o, 64'd0);
      end else begin
        e = frames_queue.pop_front();
        if (frame_count_o !== e.frames)
          report_mismatch("frame_count", frame_count_o, e.frames);
        if (conversion_ok_o !== e.ok)
          report_mismatch("conversion_ok", {63'd0, conversion_ok_o}, {63'd0, e.ok});
      end
    end
  end

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(5))
      0: v = v >> $urandom_range(63);
      1: v = v | (64'd1 << $urandom_range(63));
      default: ;
    endcase
    return v;
  endfunction

  // Stop offering and wait until every expected result has come.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (frames_queue.size() != 0);
  endtask

  // Field extremes, zero divisors and both overflow kinds.
  task automatic test_directed();
    logic [63:0] m;
    m = '1;
    send_conversion(0, 0, 0);
    send_conversion(m, 0, 48000);
    send_conversion(m, 1000, 0);
    send_conversion(0, 1, 1);
    send_conversion(m, m, 32'hFFFFFFFF);
    send_conversion(m, 1, 1);
    send_conversion(m, 1, 2);
    send_conversion(m, 2, 2);
    send_conversion(m, m - 1, 32'hFFFFFFFF);
    send_conversion(64'd10_000_000, 64'd10_000_000, 48000);
    send_conversion(64'd12345678901, 64'd10_000_000, 44100);
    send_conversion(m - 5, 64'd3, 32'd3);
    send_conversion(m, 64'hFFFFFFFF, 32'hFFFFFFFF);
    send_conversion(m, 64'h1_0000_0000, 32'hFFFFFFFF);
    send_conversion(64'h8000_0000_0000_0000, m, 32'h8000_0000);
    send_conversion(m - 1, m, 32'd1);
    send_conversion(64'd7, 64'd3, 32'hFFFFFFFF);
    wait_drained();
  endtask

  // Random traffic under one idling pattern.
  task automatic test_random(int unsigned n, int unsigned s_pct, int unsigned r_pct);
    logic [63:0] f;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) begin
      f = rand64();
      if ($urandom_range(49) == 0) f = 0;
      send_conversion(rand64(), f,
                      ($urandom_range(49) == 0) ? 32'd0 : $urandom());
    end
  endtask

  // Receiver holds off while the sender fills the pipeline, then all drains.
  task automatic test_backpressure();
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    recv_hold_cycles = 400;
    repeat (200) send_conversion(rand64(), rand64(), $urandom());
    wait_drained();
  endtask

  initial begin
    rst_ni              = 1'b0;
    in_valid_i          = 1'b0;
    out_ready_i         = 1'b0;
    tick_position_i     = '0;
    tick_frequency_i    = '0;
    frames_per_second_i = '0;
    mismatches          = 0;
    send_idle_pct       = 0;
    recv_idle_pct       = 0;
    recv_hold_cycles    = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(550, 17, 68);
    test_random(550, 68, 17);
    test_random(550, 0, 0);
    wait_drained();
    test_backpressure();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && frames_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run time limit.
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule
